FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers on aclk with the synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/lei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_pkg
// Shared types and constants of the Lorenz Euler integrator.
// ----------------------------------------------------------------------------
package lei_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_WIDTH_DEF = 32;

    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;
    localparam int TSTEP_W = 31;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_SIGMA   = 3'd0;
    localparam logic [2:0] REG_RHO     = 3'd1;
    localparam logic [2:0] REG_BETA    = 3'd2;
    localparam logic [2:0] REG_TSTEP   = 3'd3;
    localparam logic [2:0] REG_START_X = 3'd4;

    localparam logic [DATA_W-1:0]  SIGMA_RST   = 32'd655360;
    localparam logic [DATA_W-1:0]  RHO_RST     = 32'd1835008;
    localparam logic [DATA_W-1:0]  BETA_RST    = 32'd174763;
    localparam logic [TSTEP_W-1:0] TSTEP_RST   = 31'd655;
    localparam logic [DATA_W-1:0]  START_X_RST = 32'd6554;

    typedef struct packed {
        logic restart;
        logic final_step;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] lo_x;
        logic signed [31:0] lo_y;
        logic signed [31:0] lo_z;
        logic signed [31:0] hi_x;
        logic signed [31:0] hi_y;
        logic signed [31:0] hi_z;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0]   sigma;
        logic signed [31:0]   rho;
        logic signed [31:0]   beta;
        logic [TSTEP_W-1:0]   time_step;
        logic signed [31:0]   start_x;
    } cfg_t;

    typedef enum logic [1:0] {
        PH_1,
        PH_2,
        PH_3
    } phase_t;

    typedef struct packed {
        logic       accept;
        logic       prep;
        logic [2:0] start;
        phase_t     phase;
        logic       upd;
        logic       bnd;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic out_busy;
    } dp_stat_t;

endpackage

FILE: hw/rtl/lei_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_regs
// APB configuration registers: sigma, rho, beta, time step, start x.
// ----------------------------------------------------------------------------
module lei_regs import lei_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sigma     <= SIGMA_RST;
            cfg_reg.rho       <= RHO_RST;
            cfg_reg.beta      <= BETA_RST;
            cfg_reg.time_step <= TSTEP_RST;
            cfg_reg.start_x   <= START_X_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SIGMA:   cfg_reg.sigma     <= pwdata;
                REG_RHO:     cfg_reg.rho       <= pwdata;
                REG_BETA:    cfg_reg.beta      <= pwdata;
                REG_TSTEP:   cfg_reg.time_step <= pwdata[TSTEP_W-1:0];
                REG_START_X: cfg_reg.start_x   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SIGMA:   prdata = cfg_reg.sigma;
            REG_RHO:     prdata = cfg_reg.rho;
            REG_BETA:    prdata = cfg_reg.beta;
            REG_TSTEP:   prdata = {1'b0, cfg_reg.time_step};
            REG_START_X: prdata = cfg_reg.start_x;
            default:     prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/lei_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_mul
// Multi-cycle saturating fixed-point multiplier: (a*b) >> FRAC_BITS, floor.
// Magnitudes are multiplied in 32x32 partial products, one per cycle.
// ----------------------------------------------------------------------------
module lei_mul import lei_pkg::*; #(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [WORD_WIDTH-1:0] op_a,
    input  logic signed [WORD_WIDTH-1:0] op_b,
    output logic                         done,
    output logic signed [WORD_WIDTH-1:0] result
);

    localparam int W    = WORD_WIDTH;
    localparam int CHW  = 32;
    localparam int NCH  = (W + CHW - 1) / CHW;
    localparam int PADW = NCH * CHW;
    localparam int PW   = 2 * PADW;
    localparam int CIW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int SHW  = $clog2(2 * NCH);
    localparam int QW0  = 2 * W - FRAC_BITS + 1;
    localparam int QW   = (QW0 > W + 1) ? QW0 : W + 1;

    localparam logic [QW-1:0]       LIM_NEG = QW'(1) << (W - 1);
    localparam logic [QW-1:0]       LIM_POS = LIM_NEG - QW'(1);
    localparam logic signed [W-1:0] WMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] WMIN    = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [2:0] {
        M_IDLE,
        M_MUL,
        M_DRAIN,
        M_RND,
        M_SAT
    } mstate_t;

    mstate_t             state_reg;
    logic [W-1:0]        ma_reg;
    logic [W-1:0]        mb_reg;
    logic                neg_reg;
    logic [CIW-1:0]      ci_reg;
    logic [CIW-1:0]      cj_reg;
    logic [2*CHW-1:0]    pp_reg;
    logic [SHW-1:0]      sh_reg;
    logic                pp_vld_reg;
    logic [PW-1:0]       acc_reg;
    logic [QW-1:0]       q_reg;
    logic signed [W-1:0] res_reg;
    logic                done_reg;

    logic [W-1:0]        mag_a;
    logic [W-1:0]        mag_b;
    logic [PADW-1:0]     ma_pad;
    logic [PADW-1:0]     mb_pad;
    logic [CHW-1:0]      a_chunk;
    logic [CHW-1:0]      b_chunk;
    logic [PW-1:0]       pp_shift;
    logic                rem;

    assign mag_a    = op_a[W-1] ? (~op_a + 1'b1) : op_a;
    assign mag_b    = op_b[W-1] ? (~op_b + 1'b1) : op_b;
    assign ma_pad   = PADW'(ma_reg);
    assign mb_pad   = PADW'(mb_reg);
    assign a_chunk  = ma_pad[CHW*ci_reg +: CHW];
    assign b_chunk  = mb_pad[CHW*cj_reg +: CHW];
    assign pp_shift = PW'(pp_reg) << (CHW * sh_reg);
    assign rem      = |acc_reg[FRAC_BITS-1:0];

    assign done   = done_reg;
    assign result = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= M_IDLE;
            pp_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (start) begin
                        ma_reg     <= mag_a;
                        mb_reg     <= mag_b;
                        neg_reg    <= op_a[W-1] ^ op_b[W-1];
                        ci_reg     <= '0;
                        cj_reg     <= '0;
                        acc_reg    <= '0;
                        pp_vld_reg <= 1'b0;
                        state_reg  <= M_MUL;
                    end
                end
                M_MUL: begin
                    pp_reg     <= a_chunk * b_chunk;
                    sh_reg     <= SHW'(ci_reg) + SHW'(cj_reg);
                    pp_vld_reg <= 1'b1;
                    if (pp_vld_reg) begin
                        acc_reg <= acc_reg + pp_shift;
                    end
                    if (cj_reg == CIW'(NCH - 1)) begin
                        cj_reg <= '0;
                        if (ci_reg == CIW'(NCH - 1)) begin
                            state_reg <= M_DRAIN;
                        end else begin
                            ci_reg <= ci_reg + 1'b1;
                        end
                    end else begin
                        cj_reg <= cj_reg + 1'b1;
                    end
                end
                M_DRAIN: begin
                    acc_reg    <= acc_reg + pp_shift;
                    pp_vld_reg <= 1'b0;
                    state_reg  <= M_RND;
                end
                M_RND: begin
                    q_reg     <= QW'(acc_reg >> FRAC_BITS) + QW'(neg_reg & rem);
                    state_reg <= M_SAT;
                end
                M_SAT: begin
                    if (neg_reg) begin
                        res_reg <= (q_reg > LIM_NEG) ? WMIN : -q_reg[W-1:0];
                    end else begin
                        res_reg <= (q_reg > LIM_POS) ? WMAX : q_reg[W-1:0];
                    end
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: state_reg <= M_IDLE;
            endcase
        end
    end

endmodule

FILE: hw/rtl/lei_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_datapath
// Point and bounds registers, operand selection, three multiplier lanes and
// the result register.
// ----------------------------------------------------------------------------
module lei_datapath import lei_pkg::*; #(
    parameter int WORD_WIDTH = WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  in_item_t  s_data,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    input  logic      m_ready,
    output logic      m_valid,
    output out_item_t m_data
);

    localparam int W   = WORD_WIDTH;
    localparam int WP1 = W + 1;

    localparam logic signed [W-1:0]  WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]  WMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [63:0]   WMAX64 = 64'(WMAX);
    localparam logic signed [63:0]   WMIN64 = 64'(WMIN);

    function automatic logic signed [W-1:0] fit32(input logic signed [31:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        if (e > WMAX64) return WMAX;
        if (e < WMIN64) return WMIN;
        return W'(e);
    endfunction

    function automatic logic signed [W-1:0] fit_dt(input logic [TSTEP_W-1:0] v);
        logic signed [63:0] e;
        e = signed'(64'(v));
        if (e > WMAX64) return WMAX;
        return W'(e);
    endfunction

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = WP1'(a) + WP1'(b);
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = WP1'(a) - WP1'(b);
        if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
        return s[W-1:0];
    endfunction

    logic signed [W-1:0] cur_x_reg;
    logic signed [W-1:0] cur_y_reg;
    logic signed [W-1:0] cur_z_reg;
    logic signed [W-1:0] lo_reg [3];
    logic signed [W-1:0] hi_reg [3];
    logic signed [W-1:0] d_yx_reg;
    logic signed [W-1:0] d_rz_reg;
    logic signed [W-1:0] t3_reg;
    logic                last_reg;
    logic                out_vld_reg;
    out_item_t           out_reg;

    logic signed [W-1:0] sig_w;
    logic signed [W-1:0] rho_w;
    logic signed [W-1:0] beta_w;
    logic signed [W-1:0] dt_w;
    logic signed [W-1:0] sx_w;
    logic signed [W-1:0] pt [3];

    logic signed [W-1:0] op_a [3];
    logic signed [W-1:0] op_b [3];
    logic signed [W-1:0] mul_res [3];
    logic [2:0]          mul_done;

    assign sig_w  = fit32(cfg.sigma);
    assign rho_w  = fit32(cfg.rho);
    assign beta_w = fit32(cfg.beta);
    assign dt_w   = fit_dt(cfg.time_step);
    assign sx_w   = fit32(cfg.start_x);

    assign pt[0] = cur_x_reg;
    assign pt[1] = cur_y_reg;
    assign pt[2] = cur_z_reg;

    // lane 0: sigma path, lane 1: rho path, lane 2: beta path
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            op_a[i] = '0;
            op_b[i] = '0;
        end
        case (cmd.phase)
            PH_1: begin
                op_a[0] = sig_w;     op_b[0] = d_yx_reg;
                op_a[1] = cur_x_reg; op_b[1] = d_rz_reg;
                op_a[2] = cur_x_reg; op_b[2] = cur_y_reg;
            end
            PH_2: begin
                op_a[0] = mul_res[0];                      op_b[0] = dt_w;
                op_a[1] = sat_sub(mul_res[1], cur_y_reg); op_b[1] = dt_w;
                op_a[2] = beta_w;                          op_b[2] = cur_z_reg;
            end
            PH_3: begin
                op_a[2] = sat_sub(t3_reg, mul_res[2]);    op_b[2] = dt_w;
            end
            default: ;
        endcase
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        lei_mul #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_mul (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (cmd.start[g]),
            .op_a    (op_a[g]),
            .op_b    (op_b[g]),
            .done    (mul_done[g]),
            .result  (mul_res[g])
        );
    end

    assign stat.mul_done = |mul_done;
    assign stat.out_busy = out_vld_reg & ~m_ready;
    assign m_valid       = out_vld_reg;
    assign m_data        = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg   <= fit32(START_X_RST);
            cur_y_reg   <= '0;
            cur_z_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                lo_reg[i] <= WMAX;
                hi_reg[i] <= WMIN;
            end
            out_vld_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                last_reg <= s_data.final_step;
                if (s_data.restart) begin
                    cur_x_reg <= sx_w;
                    cur_y_reg <= '0;
                    cur_z_reg <= '0;
                    for (int i = 0; i < 3; i++) begin
                        lo_reg[i] <= WMAX;
                        hi_reg[i] <= WMIN;
                    end
                end
            end
            if (cmd.prep) begin
                d_yx_reg <= sat_sub(cur_y_reg, cur_x_reg);
                d_rz_reg <= sat_sub(rho_w, cur_z_reg);
            end
            // x*y leaves lane 2 when the beta*z product is issued
            if (cmd.start[2] && cmd.phase == PH_2) begin
                t3_reg <= mul_res[2];
            end
            if (cmd.upd) begin
                cur_x_reg <= sat_add(cur_x_reg, mul_res[0]);
                cur_y_reg <= sat_add(cur_y_reg, mul_res[1]);
                cur_z_reg <= sat_add(cur_z_reg, mul_res[2]);
            end
            if (cmd.bnd) begin
                for (int i = 0; i < 3; i++) begin
                    if (pt[i] < lo_reg[i]) lo_reg[i] <= pt[i];
                    if (pt[i] > hi_reg[i]) hi_reg[i] <= pt[i];
                end
            end
            if (cmd.out_load) begin
                out_reg.pos_x <= 32'(cur_x_reg);
                out_reg.pos_y <= 32'(cur_y_reg);
                out_reg.pos_z <= 32'(cur_z_reg);
                out_reg.lo_x  <= 32'(lo_reg[0]);
                out_reg.lo_y  <= 32'(lo_reg[1]);
                out_reg.lo_z  <= 32'(lo_reg[2]);
                out_reg.hi_x  <= 32'(hi_reg[0]);
                out_reg.hi_y  <= 32'(hi_reg[1]);
                out_reg.hi_z  <= 32'(hi_reg[2]);
                out_reg.last  <= last_reg;
                out_vld_reg   <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: hw/rtl/lei_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lei_ctrl
// Sequencer for one Euler step: prepare, three multiply phases, update,
// bounds, result load.
// ----------------------------------------------------------------------------
module lei_ctrl import lei_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        C_IDLE,
        C_PREP,
        C_ISSUE,
        C_WAIT1,
        C_WAIT2,
        C_WAIT3,
        C_UPD,
        C_BND,
        C_OUT
    } cstate_t;

    cstate_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            case (state_reg)
                C_IDLE:  if (s_valid) state_reg <= C_PREP;
                C_PREP:  state_reg <= C_ISSUE;
                C_ISSUE: state_reg <= C_WAIT1;
                C_WAIT1: if (stat.mul_done) state_reg <= C_WAIT2;
                C_WAIT2: if (stat.mul_done) state_reg <= C_WAIT3;
                C_WAIT3: if (stat.mul_done) state_reg <= C_UPD;
                C_UPD:   state_reg <= C_BND;
                C_BND:   state_reg <= C_OUT;
                C_OUT:   if (!stat.out_busy) state_reg <= C_IDLE;
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == C_IDLE);

    always_comb begin
        cmd          = '0;
        cmd.phase    = PH_1;
        cmd.accept   = (state_reg == C_IDLE) && s_valid;
        cmd.prep     = (state_reg == C_PREP);
        cmd.upd      = (state_reg == C_UPD);
        cmd.bnd      = (state_reg == C_BND);
        cmd.out_load = (state_reg == C_OUT) && !stat.out_busy;
        case (state_reg)
            C_ISSUE: begin
                cmd.start = 3'b111;
                cmd.phase = PH_1;
            end
            C_WAIT1: begin
                cmd.start = stat.mul_done ? 3'b111 : 3'b000;
                cmd.phase = PH_2;
            end
            C_WAIT2: begin
                cmd.start = stat.mul_done ? 3'b100 : 3'b000;
                cmd.phase = PH_3;
            end
            default: ;
        endcase
    end

endmodule

FILE: hw/rtl/lorenz_euler_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_euler_integrator
// One forward-Euler step of the Lorenz system per transfer, Q-format fixed
// point with saturation, with running per-coordinate bounds.
// ----------------------------------------------------------------------------
//  channel  | ports                             | carries
//  ---------+-----------------------------------+------------------------------
//  input    | s_valid, s_ready, s_data          | restart, final_step
//  result   | m_valid, m_ready, m_data          | point, lo/hi bounds, last
//  config   | psel, penable, pwrite, paddr, ... | sigma, rho, beta, dt, start_x
//
// The next item is accepted only once the sequencer is idle again, after the
// result load. Each item runs three dependent multiply phases on the three
// multiplier lanes; each multiply sums N*N products, N = ceil(WORD_WIDTH/32).
// Reset (synchronous, aresetn low) loads the start point and empty bounds.
// A result waiting in the output register holds the next item's result load.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lorenz_euler_integrator import lei_pkg::*; #(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    lei_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lei_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    lei_datapath #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    `ASSERT_NEVER(a_out_overwrite, cmd.out_load && m_valid && !m_ready, "result overwritten while a transfer waits")
    `ASSERT_CLK(a_load_sets_valid, cmd.out_load |=> m_valid, "result load did not raise m_valid")
    `ASSERT_NEVER(a_start_on_accept, s_valid && s_ready && (cmd.start != 3'b000), "multiply issued while accepting")

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lorenz_euler_integrator. Steps are pushed through
// the valid/ready input with random gaps. Each transfer is run through a
// Q16.16 saturating Euler model of the attractor, and every result transfer
// is checked field by field against the oldest predicted point and bounds.
// Coefficients, time step and start point are reprogrammed over APB between
// phases: defaults, extremes and random settings.
// ----------------------------------------------------------------------------
module tb;
    import lei_pkg::*;

    localparam int          FRAC      = FRAC_BITS_DEF;
    localparam longint      WMAX      = 64'sd2147483647;
    localparam longint      WMIN      = -64'sd2147483648;
    localparam int          SETTLE    = 30;
    localparam int          QUIET_MAX = 2000;
    localparam int          SHOW_MAX  = 40;
    localparam logic [2:0]  REG_NONE  = 3'd6;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_item_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_item_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lorenz_euler_integrator u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // model of the attractor state and its programmed coefficients
    logic signed [31:0] k_sigma, k_rho, k_beta, k_x0;
    logic [TSTEP_W-1:0] k_dt;
    longint             cur_pt[3];
    longint             lo_pt[3];
    longint             hi_pt[3];

    in_item_t  pending_steps[$];
    out_item_t predicted_points[$];

    int  s_gap_pct   = 0;
    int  m_stall_pct = 0;
    bit  s_took      = 1'b0;
    int  err_cnt     = 0;
    int  quiet_cnt   = 0;

    string fld_name[9] = '{"pos_x", "pos_y", "pos_z", "lo_x", "lo_y", "lo_z",
                           "hi_x", "hi_y", "hi_z"};

    function automatic longint clamp_word(longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        return clamp_word(a + b);
    endfunction

    function automatic longint sub_sat(longint a, longint b);
        return clamp_word(a - b);
    endfunction

    // floor of (a*b) >> FRAC, saturated
    function automatic longint mul_q(longint a, longint b);
        return clamp_word((a * b) >>> FRAC);
    endfunction

    function automatic void clear_bounds();
        for (int i = 0; i < 3; i++) begin
            lo_pt[i] = WMAX;
            hi_pt[i] = WMIN;
        end
    endfunction

    function automatic void apply_cfg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_SIGMA:   k_sigma = val;
            REG_RHO:     k_rho   = val;
            REG_BETA:    k_beta  = val;
            REG_TSTEP:   k_dt    = val[TSTEP_W-1:0];
            REG_START_X: k_x0    = val;
            default: ;
        endcase
    endfunction

    function automatic out_item_t lorenz_step(in_item_t it);
        longint    s, r, b, dt, dx, dy, dz;
        out_item_t o;
        s  = longint'(k_sigma);
        r  = longint'(k_rho);
        b  = longint'(k_beta);
        dt = longint'(k_dt);
        if (it.restart) begin
            cur_pt[0] = longint'(k_x0);
            cur_pt[1] = 0;
            cur_pt[2] = 0;
            clear_bounds();
        end
        dx = mul_q(mul_q(s, sub_sat(cur_pt[1], cur_pt[0])), dt);
        dy = mul_q(sub_sat(mul_q(cur_pt[0], sub_sat(r, cur_pt[2])), cur_pt[1]), dt);
        dz = mul_q(sub_sat(mul_q(cur_pt[0], cur_pt[1]), mul_q(b, cur_pt[2])), dt);
        cur_pt[0] = add_sat(cur_pt[0], dx);
        cur_pt[1] = add_sat(cur_pt[1], dy);
        cur_pt[2] = add_sat(cur_pt[2], dz);
        for (int i = 0; i < 3; i++) begin
            if (cur_pt[i] < lo_pt[i]) lo_pt[i] = cur_pt[i];
            if (cur_pt[i] > hi_pt[i]) hi_pt[i] = cur_pt[i];
        end
        o.pos_x = cur_pt[0][31:0];
        o.pos_y = cur_pt[1][31:0];
        o.pos_z = cur_pt[2][31:0];
        o.lo_x  = lo_pt[0][31:0];
        o.lo_y  = lo_pt[1][31:0];
        o.lo_z  = lo_pt[2][31:0];
        o.hi_x  = hi_pt[0][31:0];
        o.hi_y  = hi_pt[1][31:0];
        o.hi_z  = hi_pt[2][31:0];
        o.last  = it.final_step;
        return o;
    endfunction

    task automatic check_point(out_item_t want, out_item_t got);
        logic [31:0] w, g;
        for (int i = 0; i < 9; i++) begin
            w = want[288-32*i -: 32];
            g = got[288-32*i -: 32];
            if (g !== w) begin
                err_cnt++;
                if (err_cnt <= SHOW_MAX)
                    $display("%0t: %s mismatch, expected %h actual %h",
                             $time, fld_name[i], w, g);
            end
        end
        if (got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= SHOW_MAX)
                $display("%0t: last mismatch, expected %b actual %b",
                         $time, want.last, got.last);
        end
    endtask

    // step driver and m_ready back-pressure
    always @(negedge aclk) begin
        logic     nv;
        in_item_t nd;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            nv = s_valid;
            nd = s_data;
            if (!s_valid || s_took) begin
                nv = 1'b0;
                if (pending_steps.size() != 0 && $urandom_range(99) >= s_gap_pct) begin
                    nv = 1'b1;
                    nd = pending_steps.pop_front();
                end
            end
            s_valid <= nv;
            s_data  <= nd;
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    // prediction, result check and watchdog
    always @(posedge aclk) begin
        bit        busy;
        out_item_t want;
        s_took = aresetn && s_valid && s_ready;
        busy   = 1'b0;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                apply_cfg(paddr[4:2], pwdata);
                busy = 1'b1;
            end
            if (s_valid && s_ready) begin
                predicted_points.push_back(lorenz_step(s_data));
                busy = 1'b1;
            end
            if (m_valid && m_ready) begin
                busy = 1'b1;
                if (predicted_points.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= SHOW_MAX)
                        $display("%0t: unexpected result, expected none actual %h",
                                 $time, m_data);
                end else begin
                    want = predicted_points.pop_front();
                    check_point(want, m_data);
                end
            end
        end
        quiet_cnt = busy ? 0 : quiet_cnt + 1;
        if (quiet_cnt >= QUIET_MAX) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(logic [31:0] sg, logic [31:0] rh, logic [31:0] bt,
                              logic [31:0] dt, logic [31:0] x0);
        cfg_write(REG_SIGMA, sg);
        cfg_write(REG_RHO, rh);
        cfg_write(REG_BETA, bt);
        cfg_write(REG_TSTEP, dt);
        cfg_write(REG_START_X, x0);
    endtask

    task automatic wait_drain();
        while (pending_steps.size() != 0 || s_valid || predicted_points.size() != 0)
            @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic push_step(bit rs, bit fin);
        in_item_t it;
        it.restart    = rs;
        it.final_step = fin;
        pending_steps.push_back(it);
    endtask

    // trajectories: restart, a run of steps, final_step on the last; some noise
    task automatic gen_runs(int n);
        int left, len;
        left = n;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
            if (len > left) len = left;
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(9) == 0)
                    push_step($urandom_range(1), $urandom_range(1));
                else
                    push_step(k == 0, k == len - 1);
            end
            left -= len;
        end
    endtask

    task automatic random_config();
        int kind;
        kind = $urandom_range(3);
        case (kind)
            0: set_config(SIGMA_RST, RHO_RST, BETA_RST, {1'b0, TSTEP_RST}, START_X_RST);
            1: set_config($urandom_range(20 << 16), $urandom_range(50 << 16),
                          $urandom_range(5 << 16), $urandom_range(1310),
                          $urandom_range(2 << 20) - (1 << 20));
            2: set_config($urandom, $urandom, $urandom, $urandom, $urandom);
            default: set_config($urandom_range(16 << 16), $urandom_range(32 << 16),
                                $urandom_range(4 << 16), $urandom_range(65536),
                                $urandom_range(2 << 16) - (1 << 16));
        endcase
    endtask

    initial begin
        k_sigma   = SIGMA_RST;
        k_rho     = RHO_RST;
        k_beta    = BETA_RST;
        k_dt      = TSTEP_RST;
        k_x0      = START_X_RST;
        cur_pt[0] = longint'(k_x0);
        cur_pt[1] = 0;
        cur_pt[2] = 0;
        clear_bounds();
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: start from the reset point, runs, final_step, restarts
        push_step(1'b0, 1'b0);
        push_step(1'b0, 1'b0);
        push_step(1'b0, 1'b1);
        push_step(1'b0, 1'b0);
        push_step(1'b1, 1'b0);
        push_step(1'b0, 1'b0);
        push_step(1'b1, 1'b1);
        push_step(1'b0, 1'b1);
        wait_drain();

        // positive extremes: saturation on every path
        set_config(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        push_step(1'b1, 1'b0);
        push_step(1'b0, 1'b0);
        push_step(1'b0, 1'b0);
        push_step(1'b0, 1'b1);
        wait_drain();

        // negative extremes
        set_config(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        push_step(1'b1, 1'b0);
        push_step(1'b0, 1'b0);
        push_step(1'b0, 1'b0);
        push_step(1'b1, 1'b1);
        wait_drain();

        // zero time step and zero start point; unmapped register is ignored
        set_config(32'hffff0000, 32'h00010000, 32'h00008000, 32'h0, 32'h0);
        cfg_write(REG_NONE, 32'hffffffff);
        push_step(1'b1, 1'b0);
        push_step(1'b0, 1'b0);
        wait_drain();
        cfg_write(REG_TSTEP, 32'hffffffff);
        push_step(1'b0, 1'b1);
        push_step(1'b1, 1'b0);
        push_step(1'b0, 1'b1);
        wait_drain();

        for (int ph = 0; ph < 3; ph++) begin
            s_gap_pct   = (ph == 0) ? 8 : (ph == 1) ? 80 : 0;
            m_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 8 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                if (seg == 0)
                    set_config(SIGMA_RST, RHO_RST, BETA_RST, {1'b0, TSTEP_RST},
                               START_X_RST);
                else
                    random_config();
                gen_runs(162);
                wait_drain();
            end
        end

        if (err_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/lei_pkg.sv
hw/rtl/lei_regs.sv
hw/rtl/lei_mul.sv
hw/rtl/lei_datapath.sv
hw/rtl/lei_ctrl.sv
hw/rtl/lorenz_euler_integrator.sv
tb/tb.sv
